>>> src/zma_pkg.sv
// package with function codes, stage payload type and pipeline constants
`timescale 1ns / 1ps

package zma_pkg;

  typedef enum logic [3:0] {
    FN_JE       = 4'd0,
    FN_JL       = 4'd1,
    FN_JG       = 4'd2,
    FN_TEST     = 4'd3,
    FN_OR       = 4'd4,
    FN_AND      = 4'd5,
    FN_ADD      = 4'd6,
    FN_SUB      = 4'd7,
    FN_MUL      = 4'd8,
    FN_DIV      = 4'd9,
    FN_MOD      = 4'd10,
    FN_JZ       = 4'd11,
    FN_NOT      = 4'd12,
    FN_LOGSHIFT = 4'd13,
    FN_ARTSHIFT = 4'd14
  } func_t;

  localparam int WORD_W     = 16;
  localparam int BITS_PER_STG = 2;
  localparam int DIV_STGS   = WORD_W / BITS_PER_STG;
  localparam int N_STG      = DIV_STGS + 2;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t word;
    logic  stores;
    logic  branch;
    logic  cond;
    logic  derr;
    logic  use_div;
    logic  sel_mod;
    logic  neg_res;
    word_t rem;
    word_t quo;
    word_t dvsr;
  } stage_t;

endpackage

>>> src/zmachine_alu_and_branch_test.sv
// pipelined 16-bit alu and branch compare unit with a radix-4 divider pipeline
// throughput: one request per cycle, bubbles collapse, stalls back up stage by stage
// depth is set by the divider: 8 stages retiring two quotient bits each,
// plus an operand prep stage and an output select stage
// reset: synchronous rst clears every stage valid bit, payload is not reset
`timescale 1ns / 1ps

module zmachine_alu_and_branch_test import zma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func[3:0], operand_a[19:4], operand_b[35:20], operand_c[51:36],
  // operand_d[67:52], operand_count[70:68], zero[71]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_word[15:0], stores_value[16], is_branch[17], condition_true[18],
  // divide_error[19], zero[23:20]
  output logic [23:0] m_tdata
);

  stage_t     stg [N_STG];
  logic [N_STG-1:0] vld;
  logic [N_STG-1:0] rdy;
  stage_t     prep_next;

  function automatic word_t mag(input word_t v);
    mag = v[WORD_W-1] ? word_t'(-v) : v;
  endfunction

  function automatic stage_t div_step(input stage_t s);
    stage_t     r;
    logic [WORD_W:0] part;
    r = s;
    for (int k = 0; k < BITS_PER_STG; k++) begin
      part  = {r.rem, r.quo[WORD_W-1]};
      r.quo = {r.quo[WORD_W-2:0], 1'b0};
      if (part >= {1'b0, r.dvsr}) begin
        part     = part - {1'b0, r.dvsr};
        r.quo[0] = 1'b1;
      end
      r.rem = part[WORD_W-1:0];
    end
    div_step = r;
  endfunction

  function automatic stage_t finish(input stage_t s);
    stage_t r;
    word_t  val;
    r   = s;
    val = s.sel_mod ? s.rem : s.quo;
    if (s.neg_res) begin
      val = word_t'(-val);
    end
    if (s.use_div) begin
      r.word = val;
    end
    finish = r;
  endfunction

  // operand prep and all operations other than divide and modulo
  always_comb begin
    func_t       fn;
    word_t       a, b, c, d;
    logic [2:0]  cnt;
    logic [2*WORD_W-1:0] prod;
    logic [2*WORD_W-1:0] rsh;
    word_t       nb;
    logic        fill;
    word_t       shres;

    fn  = func_t'(s_tdata[3:0]);
    a   = s_tdata[19:4];
    b   = s_tdata[35:20];
    c   = s_tdata[51:36];
    d   = s_tdata[67:52];
    cnt = s_tdata[70:68];

    prod = a * b;
    fill = (fn == FN_ARTSHIFT) && a[WORD_W-1];
    nb   = word_t'(-b);
    rsh  = {{WORD_W{fill}}, a} >> nb[3:0];
    if (!b[WORD_W-1]) begin
      shres = (b[WORD_W-1:4] == '0) ? word_t'(a << b[3:0]) : '0;
    end else if (nb[WORD_W-1:4] != '0) begin
      shres = {WORD_W{fill}};
    end else begin
      shres = rsh[WORD_W-1:0];
    end

    prep_next         = '0;
    prep_next.rem     = '0;
    prep_next.quo     = mag(a);
    prep_next.dvsr    = mag(b);
    prep_next.sel_mod = (fn == FN_MOD);
    prep_next.neg_res = (fn == FN_MOD) ? a[WORD_W-1] : (a[WORD_W-1] ^ b[WORD_W-1]);

    case (fn)
      FN_JE: begin
        prep_next.branch = 1'b1;
        prep_next.cond   = (cnt >= 3'd2 && a == b) || (cnt >= 3'd3 && a == c) ||
                           (cnt >= 3'd4 && a == d);
      end
      FN_JL: begin
        prep_next.branch = 1'b1;
        prep_next.cond   = $signed(a) < $signed(b);
      end
      FN_JG: begin
        prep_next.branch = 1'b1;
        prep_next.cond   = $signed(a) > $signed(b);
      end
      FN_TEST: begin
        prep_next.branch = 1'b1;
        prep_next.cond   = (a & b) == b;
      end
      FN_OR: begin
        prep_next.stores = 1'b1;
        prep_next.word   = a | b;
      end
      FN_AND: begin
        prep_next.stores = 1'b1;
        prep_next.word   = a & b;
      end
      FN_ADD: begin
        prep_next.stores = 1'b1;
        prep_next.word   = a + b;
      end
      FN_SUB: begin
        prep_next.stores = 1'b1;
        prep_next.word   = a - b;
      end
      FN_MUL: begin
        prep_next.stores = 1'b1;
        prep_next.word   = prod[WORD_W-1:0];
      end
      FN_DIV, FN_MOD: begin
        prep_next.stores  = 1'b1;
        prep_next.derr    = (b == '0);
        prep_next.use_div = (b != '0);
      end
      FN_JZ: begin
        prep_next.branch = 1'b1;
        prep_next.cond   = (a == '0);
      end
      FN_NOT: begin
        prep_next.stores = 1'b1;
        prep_next.word   = ~a;
      end
      FN_LOGSHIFT, FN_ARTSHIFT: begin
        prep_next.stores = 1'b1;
        prep_next.word   = shres;
      end
      default: begin
        prep_next.stores = 1'b0;
      end
    endcase
  end

  // a stage takes new data when it is empty or its successor moves
  always_comb begin
    rdy[N_STG-1] = !vld[N_STG-1] || m_tready;
    for (int i = N_STG - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < N_STG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      stg[0] <= prep_next;
    end
    for (int i = 1; i <= DIV_STGS; i++) begin
      if (rdy[i]) begin
        stg[i] <= div_step(stg[i-1]);
      end
    end
    if (rdy[N_STG-1]) begin
      stg[N_STG-1] <= finish(stg[N_STG-2]);
    end
  end

  assign m_tvalid = vld[N_STG-1];
  assign m_tdata  = {4'b0000, stg[N_STG-1].derr, stg[N_STG-1].cond,
                     stg[N_STG-1].branch, stg[N_STG-1].stores, stg[N_STG-1].word};

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld))
    else $error("input blocked while a pipeline stage is empty");

  a_store_xor_branch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
    else $error("result marked as both store and branch");

  a_cond_needs_branch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[17])
    else $error("branch condition set on a non-branch result");

  a_derr_zero_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19] |-> m_tdata[16] && (m_tdata[15:0] == 16'h0000))
    else $error("divide error without a zero store");
`endif

endmodule
